// ----- design/swtm_pkg.sv -----
`timescale 1ns / 1ps
package swtm_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int AGE_W       = $clog2(MAX_WINDOW);
    localparam int FILL_W      = AGE_W + 1;
    localparam int SUM_W       = SAMPLE_BITS + AGE_W;
    localparam int LANES       = 4;
    localparam int SCAN_CYCLES = MAX_WINDOW / LANES;
    localparam int CNT_W       = 5;
    localparam int WS_W        = 7;
    localparam int TC_W        = 5;
    localparam int ADDR_W      = 3;

    // register indexes
    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [0:0] REG_TRIM_COUNT  = 1'b1;

    typedef struct packed {
        logic capture;
        logic del;
        logic ins;
        logic scan;
        logic div_load;
        logic div_step;
        logic out_load;
    } swtm_cmd_t;

    typedef struct packed {
        logic out_free;
    } swtm_stat_t;

endpackage

// ----- design/sliding_window_trimmed_mean.sv -----
`timescale 1ns / 1ps
// Sliding-window alpha-trimmed mean. Every sample word in gives one result word out:
// m_tuser is 1 once window_size samples have arrived and 2*trim_count is below
// window_size, and m_tdata is then the floor mean of the window with trim_count
// samples dropped at each end (0 otherwise). The last 64 samples live in 64 sorted
// cells tagged with their age; a new sample is captured, then the oldest cell is removed,
// the sample is inserted, the cells are walked four at a time summing the middle ranks
// of the newest window_size samples, a restoring divider is loaded and run, and the
// result is handed to the output register once that register is free. A new sample is
// accepted only after the previous one has been handed off, so samples do not overlap.
// The next sample is taken while the previous result still waits in the output
// register. Registers: window_size at 0x0 (values above 64 act as 64), trim_count at
// 0x4; write them only while the block is idle. History survives a register write.
module sliding_window_trimmed_mean
(
    input  logic                         clk,
    input  logic                         rst_n,
    // APB configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [swtm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // sample stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [15:0]                  s_tdata,   // [15:0] sample
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [15:0] trimmed_mean
    output logic                         m_tuser    // [0] mean_valid
);
    import swtm_pkg::*;

    logic [WS_W-1:0] window_size_reg;
    logic [TC_W-1:0] trim_count_reg;
    logic            cfg_wr;
    swtm_cmd_t       cmd;
    swtm_stat_t      stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // register readback
    always_comb
    begin
        case (paddr[2])
            REG_WINDOW_SIZE: prdata = {25'd0, window_size_reg};
            REG_TRIM_COUNT:  prdata = {27'd0, trim_count_reg};
            default:         prdata = '0;
        endcase
    end

    // hold configuration; reset to a 3-wide window trimming one at each end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WS_W'(3);
            trim_count_reg  <= TC_W'(1);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW_SIZE)
                window_size_reg <= pwdata[WS_W-1:0];
            else
                trim_count_reg <= pwdata[TC_W-1:0];
        end
    end

    // sequence each sample through delete, insert, walk and divide
    swtm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // sorted cells, middle-rank accumulator, divider and output word
    swtm_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (s_tdata[SAMPLE_BITS-1:0]),
        .window_size  (window_size_reg),
        .trim_count   (trim_count_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .mean_valid   (m_tuser),
        .trimmed_mean (m_tdata)
    );

endmodule

// ----- design/swtm_ctrl.sv -----
`timescale 1ns / 1ps
module swtm_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  swtm_pkg::swtm_stat_t stat,
    output swtm_pkg::swtm_cmd_t  cmd
);
    import swtm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEL  = 3'd1;
    localparam logic [2:0] ST_INS  = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DIVL = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(SCAN_CYCLES - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DEL;
                end
            end
            ST_DEL:
            begin
                cmd.del    = 1'b1;
                state_next = ST_INS;
            end
            ST_INS:
            begin
                cmd.ins    = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                    state_next = ST_DIVL;
            end
            ST_DIVL:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- design/swtm_dp.sv -----
`timescale 1ns / 1ps
module swtm_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  swtm_pkg::swtm_cmd_t                 cmd,
    output swtm_pkg::swtm_stat_t                stat,
    input  logic [swtm_pkg::SAMPLE_BITS-1:0]    sample,
    input  logic [swtm_pkg::WS_W-1:0]           window_size,
    input  logic [swtm_pkg::TC_W-1:0]           trim_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                mean_valid,
    output logic [swtm_pkg::SAMPLE_BITS-1:0]    trimmed_mean
);
    import swtm_pkg::*;

    // sorted cells: ascending values, each with its age in samples
    logic [SAMPLE_BITS-1:0] val_reg [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] val_next [MAX_WINDOW];
    logic [AGE_W-1:0]       age_reg [MAX_WINDOW];
    logic [AGE_W-1:0]       age_next [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  vld_reg, vld_next;

    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      rank_reg, rank_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [SUM_W-1:0]       quo_reg;
    logic [WS_W-1:0]        rem_reg;
    logic                   out_valid_reg;
    logic                   mean_valid_reg;
    logic [SAMPLE_BITS-1:0] mean_reg;

    logic [WS_W-1:0]        w_eff;
    logic [WS_W-1:0]        hi_rank;
    logic [WS_W-1:0]        divisor;
    logic                   win_ok;
    logic [MAX_WINDOW-1:0]  del_hit;
    logic [MAX_WINDOW-1:0]  above;
    logic [MAX_WINDOW-1:0]  mv;
    logic                   or_acc;
    logic                   inw;
    logic [WS_W:0]          trial;

    assign w_eff   = (window_size > WS_W'(MAX_WINDOW)) ? WS_W'(MAX_WINDOW) : window_size;
    assign hi_rank = w_eff - {2'b00, trim_count};
    assign divisor = w_eff - {1'b0, trim_count, 1'b0};
    assign win_ok  = (fill_reg >= w_eff) && ({1'b0, trim_count, 1'b0} < w_eff);

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign mean_valid    = mean_valid_reg;
    assign trimmed_mean  = mean_reg;

    always_comb
    begin
        or_acc    = 1'b0;
        rank_next = rank_reg;
        acc_next  = acc_reg;
        inw       = 1'b0;
        vld_next  = vld_reg;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            val_next[i] = val_reg[i];
            age_next[i] = age_reg[i];
            del_hit[i]  = vld_reg[i] && (age_reg[i] == AGE_W'(MAX_WINDOW - 1));
            or_acc      = or_acc | del_hit[i];
            above[i]    = or_acc;
            mv[i]       = !vld_reg[i] || (val_reg[i] > sample_reg);
        end
        if (cmd.del)
        begin
            // drop the oldest cell, close the gap
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                if (above[i])
                begin
                    if (i == MAX_WINDOW - 1)
                        vld_next[i] = 1'b0;
                    else
                    begin
                        val_next[i] = val_reg[i+1];
                        age_next[i] = age_reg[i+1];
                        vld_next[i] = vld_reg[i+1];
                    end
                end
            end
        end
        else if (cmd.ins)
        begin
            // open a slot ahead of the first larger value, age everyone
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                if (mv[i])
                begin
                    if (i > 0 && mv[i-1])
                    begin
                        val_next[i] = val_reg[i-1];
                        age_next[i] = age_reg[i-1] + 1'b1;
                        vld_next[i] = vld_reg[i-1];
                    end
                    else
                    begin
                        val_next[i] = sample_reg;
                        age_next[i] = '0;
                        vld_next[i] = 1'b1;
                    end
                end
                else
                    age_next[i] = age_reg[i] + 1'b1;
            end
            rank_next = '0;
            acc_next  = '0;
        end
        else if (cmd.scan)
        begin
            // count window members in sorted order, sum the middle ranks
            for (int k = 0; k < LANES; k++)
            begin
                inw = vld_reg[k] && ({1'b0, age_reg[k]} < w_eff);
                if (inw)
                begin
                    if (rank_next >= {2'b00, trim_count} && rank_next < hi_rank)
                        acc_next = acc_next + SUM_W'(val_reg[k]);
                    rank_next = rank_next + 1'b1;
                end
            end
            // rotate the cells so the next group sits at the front
            for (int i = 0; i < MAX_WINDOW; i++)
            begin
                val_next[i] = val_reg[(i + LANES) % MAX_WINDOW];
                age_next[i] = age_reg[(i + LANES) % MAX_WINDOW];
                vld_next[i] = vld_reg[(i + LANES) % MAX_WINDOW];
            end
        end
    end

    assign trial = {rem_reg, quo_reg[SUM_W-1]};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            val_reg[i] <= val_next[i];
            age_reg[i] <= age_next[i];
        end
        acc_reg <= acc_next;
        if (cmd.capture)
            sample_reg <= sample;
        if (cmd.div_load)
        begin
            quo_reg <= acc_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_reg <= WS_W'(trial - {1'b0, divisor});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[WS_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
            mean_reg <= win_ok ? quo_reg[SAMPLE_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            fill_reg       <= '0;
            rank_reg       <= '0;
            out_valid_reg  <= 1'b0;
            mean_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            rank_reg <= rank_next;
            if (cmd.ins && fill_reg != FILL_W'(MAX_WINDOW))
                fill_reg <= fill_reg + 1'b1;
            if (cmd.out_load)
            begin
                out_valid_reg  <= 1'b1;
                mean_valid_reg <= win_ok;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ins |-> ($countones(vld_reg) == 32'(fill_reg)))
        else $error("cell count differs from fill count");

    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(del_hit))
        else $error("more than one cell holds the oldest age");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && !win_ok |=> (trimmed_mean == '0 && !mean_valid))
        else $error("invalid result carries nonzero mean");

endmodule
